// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL core to check its own logic.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MRFL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MRFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/mrfl_pkg.sv =====
// Shared constants and types of the magnet region field lookup.
// Depends on nothing.
package mrfl_pkg;

  localparam int MAX_MAGNETS_DEF = 8;
  localparam int COORD_BITS_DEF  = 20;
  localparam int RADIUS_W        = 19;
  localparam int FIELD_W         = 32;
  localparam int STATUS_W        = 2;
  localparam int INDEX_W         = 3;
  localparam int DIGIT_W         = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_HIT    = 2'd2,
    ST_MISS   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REQ_APPEND = 1'b0,
    REQ_QUERY  = 1'b1
  } req_t;

endpackage

// ===== hdl/mrfl_in_if.sv =====
// Request channel of the magnet region field lookup: valid, ready and the item.
// Depends on mrfl_pkg.
interface mrfl_in_if import mrfl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [RADIUS_W-1:0]          radius;
  logic signed [FIELD_W-1:0]    field_strength;

  modport source (output valid, req_type, pos_x, pos_y, pos_z, radius, field_strength,
                  input ready);
  modport sink (input valid, req_type, pos_x, pos_y, pos_z, radius, field_strength,
                output ready);
endinterface

// ===== hdl/mrfl_out_if.sv =====
// Result channel of the magnet region field lookup: valid, ready and the item.
// Depends on mrfl_pkg.
interface mrfl_out_if import mrfl_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [INDEX_W-1:0]        hit_slot;
  logic signed [FIELD_W-1:0] bz;

  modport source (output valid, status, hit_slot, bz, input ready);
  modport sink (input valid, status, hit_slot, bz, output ready);
endinterface

// ===== hdl/magnet_region_field_lookup_core.sv =====
// Top level of the magnet region field lookup: table memory, search sequencer, result register.
// Depends on mrfl_pkg, mrfl_in_if, mrfl_out_if and assert_macros.svh.
//
// The block holds up to MAX_MAGNETS magnets in one synchronous table memory, in load order.
// An append item writes the next free entry and answers "loaded", or "table full" once every
// entry is used. A query item walks the loaded entries in order, one entry at a time, and
// answers the first magnet whose region (its sphere, cut by the direction test) holds the
// point, or a miss. Each entry takes a memory read, forming the offsets p-c, ten products on
// the shared signed multiplier (each summed the cycle after it is formed), a check and, when
// the entry misses, an advance. When the point lies inside the sphere but on the far side of
// the centre plane, the exact direction test needs two wide products, built by a digit-serial
// unit that takes 8 bits per cycle over ND digits each, with
// ND = ceil((2*max(COORD_BITS+1,20)+5)/8), which is 6 at the default widths.
// The result sits in an output register, so a new item is taken while it waits.
`include "assert_macros.svh"

module magnet_region_field_lookup_core import mrfl_pkg::*; #(
  parameter int MAX_MAGNETS = MAX_MAGNETS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mrfl_in_if.sink   in_ch,
  mrfl_out_if.source out_ch
);

  localparam int IW  = (MAX_MAGNETS > 1) ? $clog2(MAX_MAGNETS) : 1;
  localparam int CW  = $clog2(MAX_MAGNETS + 1);
  localparam int EW  = 3 * COORD_BITS + RADIUS_W + FIELD_W;
  localparam int RW  = COORD_BITS + 1;
  localparam int OW  = (COORD_BITS + 1 > RADIUS_W + 1) ? COORD_BITS + 1 : RADIUS_W + 1;
  localparam int PW  = 2 * OW;
  localparam int AW  = PW + 2;
  localparam int MW  = AW + 3;
  localparam int ND  = (MW + DIGIT_W - 1) / DIGIT_W;
  localparam int BW  = ND * DIGIT_W;
  localparam int DCW = $clog2(ND) + 1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD   = 10'b00_0000_0010,
    S_REL  = 10'b00_0000_0100,
    S_MUL  = 10'b00_0000_1000,
    S_CHK  = 10'b00_0001_0000,
    S_BM1  = 10'b00_0010_0000,
    S_BM2  = 10'b00_0100_0000,
    S_CMP  = 10'b00_1000_0000,
    S_NEXT = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] idx_r;
  logic          out_valid_r;

  // Table memory, one packed entry per magnet: centre x, y, z, radius, field.
  logic [EW-1:0] mem [MAX_MAGNETS];
  logic [EW-1:0] rd_r;

  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;
  logic signed [RW-1:0]         relx_r, rely_r, relz_r;
  logic [3:0]                   step_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [AW-1:0]         dist_r, dot_r, cen_r, rsq_r;
  logic [MW-1:0]                d_r, ba_r;
  logic [BW-1:0]                bb_r;
  logic [2*BW-1:0]              bacc_r, big1_r;
  logic [DCW-1:0]               dig_r;
  status_t                      res_status_r;
  logic [INDEX_W-1:0]           res_idx_r;
  logic signed [FIELD_W-1:0]    res_bz_r;
  status_t                      out_status_r;
  logic [INDEX_W-1:0]           out_idx_r;
  logic signed [FIELD_W-1:0]    out_bz_r;

  logic                         in_fire, out_free, is_append, has_room, last_entry, dig_last;
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic [RADIUS_W-1:0]          rr;
  logic signed [FIELD_W-1:0]    ff;
  logic signed [OW-1:0]         opa, opb;
  logic signed [PW-1:0]         mul_full;
  logic signed [AW-1:0]         prod_ext, neg_dot;
  logic [MW-1:0]                neg_u, d_nxt;
  logic [MW+DIGIT_W-1:0]        bpart;
  logic [2*BW-1:0]              bacc_nxt;
  logic [IW+INDEX_W-1:0]        idx_wide;
  logic [INDEX_W-1:0]           hit_idx;
  logic [CW-1:0]                idx_plus;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign is_append    = (in_ch.req_type == REQ_APPEND);
  assign has_room     = (count_r < CW'(MAX_MAGNETS));
  assign idx_plus     = CW'(idx_r) + CW'(1);
  assign last_entry   = (idx_plus == count_r);
  assign dig_last     = (dig_r == DCW'(ND - 1));

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.hit_slot = out_idx_r;
  assign out_ch.bz       = out_bz_r;

  // Fields of the entry read last cycle.
  assign cx = rd_r[EW-1 -: COORD_BITS];
  assign cy = rd_r[EW-COORD_BITS-1 -: COORD_BITS];
  assign cz = rd_r[EW-2*COORD_BITS-1 -: COORD_BITS];
  assign rr = rd_r[FIELD_W +: RADIUS_W];
  assign ff = rd_r[FIELD_W-1:0];

  // The reported index is the low bits of the table position.
  assign idx_wide = {{INDEX_W{1'b0}}, idx_r};
  assign hit_idx  = idx_wide[INDEX_W-1:0];

  // Shared multiplier: squared offsets, offset times centre, squared centre, squared radius.
  always_comb begin
    case (step_r)
      4'd0: begin opa = OW'(relx_r); opb = OW'(relx_r); end
      4'd1: begin opa = OW'(rely_r); opb = OW'(rely_r); end
      4'd2: begin opa = OW'(relz_r); opb = OW'(relz_r); end
      4'd3: begin opa = OW'(relx_r); opb = OW'(cx); end
      4'd4: begin opa = OW'(rely_r); opb = OW'(cy); end
      4'd5: begin opa = OW'(relz_r); opb = OW'(cz); end
      4'd6: begin opa = OW'(cx); opb = OW'(cx); end
      4'd7: begin opa = OW'(cy); opb = OW'(cy); end
      4'd8: begin opa = OW'(cz); opb = OW'(cz); end
      4'd9: begin
        opa = OW'(signed'({1'b0, rr}));
        opb = OW'(signed'({1'b0, rr}));
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign mul_full = opa * opb;
  assign prod_ext = AW'(prod_r);

  // The dot product is negative on the slow path; d = 5 * |dot|.
  assign neg_dot = -dot_r;
  assign neg_u   = MW'($unsigned(neg_dot));
  assign d_nxt   = (neg_u << 2) + neg_u;

  // Digit-serial wide multiplier, most significant digit of the B operand first.
  assign bpart    = {{DIGIT_W{1'b0}}, ba_r} * {{MW{1'b0}}, bb_r[BW-1 -: DIGIT_W]};
  assign bacc_nxt = (bacc_r << DIGIT_W) + (2*BW)'(bpart);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result loads the output register; otherwise a taken result empties it.
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (is_append) begin
              if (has_room) begin
                count_r <= count_r + CW'(1);
              end
              state_r <= S_FIN;
            end else if (count_r == '0) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD:   state_r <= S_REL;
        S_REL:  state_r <= S_MUL;
        S_MUL: begin
          if (step_r == 4'd10) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (dist_r > rsq_r) begin
            state_r <= S_NEXT;
          end else if (dot_r >= 0) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_BM1;
          end
        end
        S_BM1: begin
          if (dig_last) begin
            state_r <= S_BM2;
          end
        end
        S_BM2: begin
          if (dig_last) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (big1_r >= bacc_r) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (last_entry) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Table memory: one write port for appends, one registered read port for the search.
  always_ff @(posedge clk) begin
    if (in_fire && is_append && has_room) begin
      mem[count_r[IW-1:0]] <= {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                               in_ch.radius, in_ch.field_strength};
    end
    rd_r <= mem[idx_r];
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          px_r      <= in_ch.pos_x;
          py_r      <= in_ch.pos_y;
          pz_r      <= in_ch.pos_z;
          idx_r     <= '0;
          res_idx_r <= '0;
          res_bz_r  <= '0;
          if (is_append) begin
            res_status_r <= has_room ? ST_LOADED : ST_FULL;
          end else begin
            res_status_r <= ST_MISS;
          end
        end
      end
      S_REL: begin
        relx_r <= RW'(px_r) - RW'(cx);
        rely_r <= RW'(py_r) - RW'(cy);
        relz_r <= RW'(pz_r) - RW'(cz);
        step_r <= '0;
        dist_r <= '0;
        dot_r  <= '0;
        cen_r  <= '0;
        rsq_r  <= '0;
      end
      S_MUL: begin
        prod_r <= mul_full;
        step_r <= step_r + 4'd1;
        // Each product is summed the cycle after it is formed.
        case (step_r) inside
          [4'd1:4'd3]: dist_r <= dist_r + prod_ext;
          [4'd4:4'd6]: dot_r  <= dot_r + prod_ext;
          [4'd7:4'd9]: cen_r  <= cen_r + prod_ext;
          4'd10:       rsq_r  <= prod_ext;
          default: ;
        endcase
      end
      S_CHK: begin
        d_r    <= d_nxt;
        ba_r   <= MW'($unsigned(rsq_r));
        bb_r   <= BW'($unsigned(cen_r));
        bacc_r <= '0;
        dig_r  <= '0;
        if (!(dist_r > rsq_r) && (dot_r >= 0)) begin
          res_status_r <= ST_HIT;
          res_idx_r    <= hit_idx;
          res_bz_r     <= ff;
        end
      end
      S_BM1: begin
        if (dig_last) begin
          // r^2 * |c|^2 is done; start d * d.
          big1_r <= bacc_nxt;
          ba_r   <= d_r;
          bb_r   <= BW'(d_r);
          bacc_r <= '0;
          dig_r  <= '0;
        end else begin
          bacc_r <= bacc_nxt;
          bb_r   <= bb_r << DIGIT_W;
          dig_r  <= dig_r + DCW'(1);
        end
      end
      S_BM2: begin
        bacc_r <= bacc_nxt;
        bb_r   <= bb_r << DIGIT_W;
        dig_r  <= dig_r + DCW'(1);
      end
      S_CMP: begin
        if (big1_r >= bacc_r) begin
          res_status_r <= ST_HIT;
          res_idx_r    <= hit_idx;
          res_bz_r     <= ff;
        end
      end
      S_NEXT: begin
        if (!last_entry) begin
          idx_r <= idx_plus[IW-1:0];
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_idx_r    <= res_idx_r;
          out_bz_r     <= res_bz_r;
        end
      end
      default: ;
    endcase
  end

  `MRFL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_MAGNETS))
  `MRFL_ASSERT_NOW(a_search_in_table, state_r == S_RD, CW'(idx_r) < count_r)
  `MRFL_ASSERT_NEXT(a_append_counts, in_fire && is_append && has_room,
                    count_r == $past(count_r) + CW'(1))
  `MRFL_ASSERT_NEXT(a_fin_delivers, state_r == S_FIN && out_free, out_valid_r)

endmodule
